// ----- design/ipdv_pkg.sv -----
// shared types and constants of the image pack directory validator
package ipdv_pkg;

	localparam int NameBytes = 15;
	localparam int NameW = NameBytes * 8;
	localparam int IdxW = 12;
	localparam int CntW = 13;
	localparam int LenW = 27;
	localparam logic [LenW-1:0] HdrLen = 27'd12;
	localparam logic [LenW-1:0] MaxFile = 27'd67108864;
	localparam logic [CntW-1:0] MaxImages = 13'd4096;

	typedef enum logic [3:0] {
		ST_OK = 4'd0, ST_SIZE = 4'd1, ST_MAGIC = 4'd2, ST_MISMATCH = 4'd3,
		ST_COUNT = 4'd4, ST_DIR_OVR = 4'd5, ST_UNTERM = 4'd6, ST_EMPTY = 4'd7,
		ST_BAD_CHAR = 4'd8, ST_PADDING = 4'd9, ST_DUP = 4'd10, ST_ZERO = 4'd11,
		ST_ALIGN = 4'd12, ST_OVER_DIR = 4'd13, ST_OVERLAP = 4'd14, ST_DATA_OVR = 4'd15
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE, S_HEADER, S_DIR, S_CHECK, S_WALK, S_GEOM, S_OUT, S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic start;      // new file with this byte
		logic take_byte;  // store byte at position
		logic hdr_check;  // evaluate header on byte 11
		logic magic_check;
		logic ent_check;  // evaluate name checks of finished entry
		logic walk_first; // launch first name read
		logic walk_step;  // compare returned name, launch next read
		logic geom;       // evaluate geometry
		logic commit;     // result taken, store name, advance
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       hdr_done;   // header fully received
		logic       hdr_fail;
		logic       magic_fail;
		logic       ent_done;   // entry byte 23 received
		logic       name_fail;
		logic       walk_none;  // no stored names to compare
		logic       walk_end;   // compare of last stored name
		logic       walk_hit;
		logic       geom_fail;
		logic       last_entry;
	} stat_t;

	function automatic logic name_char_ok(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h30 && c <= 8'h39) || c == 8'h5f;
	endfunction

endpackage

// ----- design/ipdv_ram.sv -----
// generic single port ram with registered read
module ipdv_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	input  logic [Width-1:0]         dummy_unused_n,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr] & ~dummy_unused_n;
	end
endmodule

// ----- design/ipdv_ctrl.sv -----
// controller state machine of the validator
module ipdv_ctrl import ipdv_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output logic  out_valid,
	input  logic  out_stall,
	input  logic  start_of_file,
	input  logic  len_bad,
	input  stat_t st,
	output cmd_t  cmd
);
	state_t state_q, state_d;
	logic acc;

	assign acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE, S_DONE, S_HEADER, S_DIR: begin
				in_stall = 1'b0;
				if (acc && start_of_file) begin
					cmd.start = 1'b1;
					if (len_bad) begin
						state_d = S_OUT;
					end else begin
						cmd.take_byte = 1'b1;
						state_d = S_HEADER;
					end
				end else if (acc && state_q == S_HEADER) begin
					cmd.take_byte = 1'b1;
					cmd.magic_check = 1'b1;
					cmd.hdr_check = 1'b1;
					if (st.magic_fail || (st.hdr_done && st.hdr_fail)) begin
						state_d = S_OUT;
					end else if (st.hdr_done) begin
						state_d = S_DIR;
					end
				end else if (acc && state_q == S_DIR) begin
					cmd.take_byte = 1'b1;
					if (st.ent_done) begin
						state_d = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				cmd.ent_check = 1'b1;
				cmd.walk_first = 1'b1;
				if (st.name_fail) begin
					state_d = S_OUT;
				end else if (st.walk_none) begin
					state_d = S_GEOM;
				end else begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				if (st.walk_hit) begin
					state_d = S_OUT;
				end else if (st.walk_end) begin
					state_d = S_GEOM;
				end
			end
			S_GEOM: begin
				cmd.geom = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					cmd.commit = 1'b1;
					state_d = st.last_entry ? S_DONE : S_DIR;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

`ifndef ASSERT_OFF
	a_no_input_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT |-> in_stall) else $error("input taken while result pending");
	a_walk_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_GEOM |=> state_q == S_OUT) else $error("geometry not followed by result");
	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> out_valid) else $error("commit without valid");
`endif
endmodule

// ----- design/ipdv_dp.sv -----
// datapath: byte capture, checks, name store and result registers
module ipdv_dp import ipdv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  logic [7:0]       data_byte,
	input  logic [LenW-1:0]  file_length,
	output logic             len_bad,
	output stat_t            st,
	output logic [3:0]       status,
	output logic [11:0]      entry_index,
	output logic [15:0]      width,
	output logic [15:0]      height,
	output logic [25:0]      color_offset,
	output logic [25:0]      alpha_offset,
	output logic [12:0]      image_count,
	output logic             last
);
	logic [7:0]  bytes_q [24];
	logic [4:0]  pos_q;
	logic [CntW-1:0] count_q, done_q;
	logic [31:0] total_q;
	logic [LenW:0] prev_q;
	logic [IdxW-1:0] walk_q;
	logic [NameW-1:0] rdata, name;
	logic        ram_we;
	logic [IdxW-1:0] ram_addr;
	logic [31:0] area_q;
	logic [33:0] need3, area2;
	logic [33:0] dir_end;

	assign len_bad = file_length < HdrLen || file_length > MaxFile;

	always_comb begin
		for (int k = 0; k < NameBytes; k++) begin
			name[k*8 +: 8] = bytes_q[k];
		end
	end

	// header fields with current byte folded in
	logic [7:0]  b11;
	logic [31:0] hcount, htotal;
	logic [33:0] hdir_end;
	logic        hcount_bad;
	assign b11 = data_byte;
	assign hcount = {bytes_q[7], bytes_q[6], bytes_q[5], bytes_q[4]};
	assign htotal = {b11, bytes_q[10], bytes_q[9], bytes_q[8]};
	assign hdir_end = 34'd12 + {2'b0, hcount} * 34'd24;
	assign dir_end = 34'd12 + {21'b0, count_q} * 34'd24;
	assign hcount_bad = hcount == 32'd0 || hcount > {19'b0, MaxImages};

	assign st.hdr_done = pos_q == 5'd11;
	assign st.magic_fail = pos_q == 5'd3 &&
		{data_byte, bytes_q[2], bytes_q[1], bytes_q[0]} != 32'h31474d49;
	assign st.hdr_fail = htotal != {5'b0, file_length} || hcount_bad ||
		hdir_end > {2'b0, htotal};
	assign st.ent_done = pos_q == 5'd23;
	assign st.walk_none = done_q == '0;
	assign st.walk_end = {1'b0, walk_q} == done_q - 13'd1;
	assign st.walk_hit = rdata == name;
	assign st.last_entry = last;

	// name checks, combinational over sixteen bytes
	logic [3:0] name_st;
	always_comb begin
		logic found, bad, pad;
		logic [4:0] nul;
		found = 1'b0; nul = 5'd16; bad = 1'b0; pad = 1'b0;
		for (int k = 0; k <= NameBytes; k++) begin
			if (!found && bytes_q[k] == 8'd0) begin
				found = 1'b1;
				nul = 5'(k);
			end
		end
		for (int k = 0; k <= NameBytes; k++) begin
			if (5'(k) < nul && !name_char_ok(bytes_q[k])) bad = 1'b1;
			if (5'(k) > nul && bytes_q[k] != 8'd0) pad = 1'b1;
		end
		if (!found) name_st = ST_UNTERM;
		else if (nul == 5'd0) name_st = ST_EMPTY;
		else if (bad) name_st = ST_BAD_CHAR;
		else if (pad) name_st = ST_PADDING;
		else name_st = ST_OK;
	end
	assign st.name_fail = name_st != ST_OK;

	logic [15:0] w, h;
	logic [31:0] off;
	assign w = {bytes_q[17], bytes_q[16]};
	assign h = {bytes_q[19], bytes_q[18]};
	assign off = {bytes_q[23], bytes_q[22], bytes_q[21], bytes_q[20]};
	assign need3 = {2'b0, area_q} + {1'b0, area_q, 1'b0};
	assign area2 = {1'b0, area_q, 1'b0};

	logic [3:0] geo_st;
	always_comb begin
		if (w == '0 || h == '0) geo_st = ST_ZERO;
		else if (off[1:0] != 2'b0) geo_st = ST_ALIGN;
		else if ({2'b0, off} < dir_end) geo_st = ST_OVER_DIR;
		else if ({2'b0, off} < {6'b0, prev_q}) geo_st = ST_OVERLAP;
		else if ({2'b0, off} + need3 > {2'b0, total_q}) geo_st = ST_DATA_OVR;
		else geo_st = ST_OK;
	end
	assign st.geom_fail = geo_st != ST_OK;

	assign ram_we = cmd.commit && status == ST_OK;
	assign ram_addr = ram_we ? done_q[IdxW-1:0] :
		(cmd.walk_first ? '0 : walk_q + 12'd1);

	ipdv_ram #(.Width(NameW), .Depth(1 << IdxW)) u_names (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(name),
		.dummy_unused_n('0), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			done_q <= '0;
			count_q <= '0;
		end else if (cmd.start) begin
			pos_q <= cmd.take_byte ? 5'd1 : 5'd0;
			done_q <= '0;
			count_q <= '0;
		end else begin
			if (cmd.take_byte) begin
				pos_q <= (pos_q == 5'd23 || (st.hdr_done && cmd.hdr_check)) ? '0
					: pos_q + 5'd1;
			end
			if (cmd.hdr_check && st.hdr_done) count_q <= hcount[CntW-1:0];
			if (ram_we) done_q <= done_q + 13'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int k = 1; k < 24; k++) bytes_q[k] <= 8'd0;
			bytes_q[0] <= cmd.take_byte ? data_byte : 8'd0;
		end else if (cmd.take_byte) begin
			bytes_q[pos_q] <= data_byte;
		end
		if (cmd.walk_first) walk_q <= '0;
		else if (cmd.walk_step) walk_q <= walk_q + 12'd1;
		if (cmd.ent_check) area_q <= w * h;
		if (cmd.hdr_check && st.hdr_done) begin
			total_q <= htotal;
			prev_q <= hdir_end[LenW:0];
		end
		if (ram_we) prev_q <= off[LenW:0] + need3[LenW:0];
		// result register
		if (cmd.start && len_bad) begin
			{status, entry_index, width, height} <= {ST_SIZE, 44'd0};
			{color_offset, alpha_offset, image_count} <= '0;
			last <= 1'b1;
		end else if (cmd.magic_check && st.magic_fail) begin
			{status, entry_index, width, height} <= {ST_MAGIC, 44'd0};
			{color_offset, alpha_offset, image_count} <= '0;
			last <= 1'b1;
		end else if (cmd.hdr_check && st.hdr_done && st.hdr_fail) begin
			{entry_index, width, height, color_offset, alpha_offset} <= '0;
			last <= 1'b1;
			if (htotal != {5'b0, file_length}) begin
				status <= ST_MISMATCH;
				image_count <= '0;
			end else if (hcount_bad) begin
				status <= ST_COUNT;
				image_count <= '0;
			end else begin
				status <= ST_DIR_OVR;
				image_count <= hcount[CntW-1:0];
			end
		end else if (cmd.ent_check && st.name_fail) begin
			status <= name_st;
			entry_index <= done_q[IdxW-1:0];
			{width, height, color_offset, alpha_offset} <= '0;
			image_count <= count_q;
			last <= 1'b1;
		end else if (cmd.walk_step && st.walk_hit) begin
			status <= ST_DUP;
			entry_index <= done_q[IdxW-1:0];
			{width, height, color_offset, alpha_offset} <= '0;
			image_count <= count_q;
			last <= 1'b1;
		end else if (cmd.geom) begin
			status <= geo_st;
			entry_index <= done_q[IdxW-1:0];
			image_count <= count_q;
			if (geo_st == ST_OK) begin
				width <= w;
				height <= h;
				color_offset <= off[25:0];
				alpha_offset <= off[25:0] + area2[25:0];
				last <= (done_q + 13'd1) >= count_q;
			end else begin
				{width, height, color_offset, alpha_offset} <= '0;
				last <= 1'b1;
			end
		end
	end

	logic unused;
	assign unused = ^{need3[33:28], area2[33:26], off[31:26]};

`ifndef ASSERT_OFF
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= 5'd23) else $error("byte position out of range");
	a_store_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> done_q < count_q) else $error("name stored beyond count");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step |-> {1'b0, walk_q} < done_q) else $error("walk past stored names");
`endif
endmodule

// ----- design/image_pack_directory_validator.sv -----
// top level of the image pack directory validator
// Takes one file byte per cycle while parsing the 12-byte header and each
// 24-byte entry. After each entry's last byte the block stops taking bytes
// while a walk over the name store (one read per cycle from a single-port
// ram) looks for a duplicate name among the entries already accepted in the
// file; the result then waits in an output register until transferred.
// Errors end the file with last set; later bytes are dropped until a byte
// with start_of_file.
module image_pack_directory_validator import ipdv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [26:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        start_of_file,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  status,
	output logic [11:0] entry_index,
	output logic [15:0] width,
	output logic [15:0] height,
	output logic [25:0] color_offset,
	output logic [25:0] alpha_offset,
	output logic [12:0] image_count,
	output logic        last
);
	logic [LenW-1:0] file_length_q;
	cmd_t  cmd;
	stat_t st;
	logic  len_bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= '0;
		end else if (cfg_we) begin
			file_length_q <= cfg_wdata;
		end
	end

	ipdv_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .start_of_file(start_of_file),
		.len_bad(len_bad), .st(st), .cmd(cmd)
	);

	ipdv_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .data_byte(data_byte),
		.file_length(file_length_q), .len_bad(len_bad), .st(st),
		.status(status), .entry_index(entry_index), .width(width), .height(height),
		.color_offset(color_offset), .alpha_offset(alpha_offset),
		.image_count(image_count), .last(last)
	);
endmodule

// ----- sim/image_pack_directory_validator_test.sv -----
// testbench of the image pack directory validator: random files checked against a byte-level model
`timescale 1ns / 1ps
module image_pack_directory_validator_test import ipdv_pkg::*;;

	typedef struct {
		logic [7:0] b;
		logic       sof;
	} file_byte_t;

	typedef struct {
		status_t     st;
		logic [11:0] idx;
		logic [15:0] w;
		logic [15:0] h;
		logic [25:0] co;
		logic [25:0] ao;
		logic [12:0] cnt;
		logic        lst;
	} entry_report_t;

	localparam longint FileMax = 64 * 1024 * 1024;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [26:0] cfg_wdata = '0;
	logic in_valid = 0;
	logic in_stall;
	logic [7:0] data_byte = '0;
	logic start_of_file = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [3:0] status;
	logic [11:0] entry_index;
	logic [15:0] width;
	logic [15:0] height;
	logic [25:0] color_offset;
	logic [25:0] alpha_offset;
	logic [12:0] image_count;
	logic last;

	image_pack_directory_validator dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
		.start_of_file(start_of_file), .out_valid(out_valid), .out_stall(out_stall),
		.status(status), .entry_index(entry_index), .width(width), .height(height),
		.color_offset(color_offset), .alpha_offset(alpha_offset),
		.image_count(image_count), .last(last)
	);

	always #2 clk = ~clk;

	file_byte_t byte_q[$];
	entry_report_t report_q[$];
	int errors = 0;
	int bytes_queued = 0;
	longint cyc = 0;

	// parser copy
	longint file_len = 0;
	state_t phase = S_IDLE;
	int unsigned pos = 0;
	logic [7:0] hold[24];
	longint decl_cnt = 0, decl_total = 0, prev_end = 0;
	int unsigned accepted = 0;
	logic [NameW-1:0] seen_names[4096];

	function automatic entry_report_t mk(status_t st, longint idx, longint w, longint h,
			longint co, longint ao, longint cnt, bit lst);
		entry_report_t r;
		r.st = st; r.idx = idx[11:0]; r.w = w[15:0]; r.h = h[15:0];
		r.co = co[25:0]; r.ao = ao[25:0]; r.cnt = cnt[12:0]; r.lst = lst;
		if (lst)
			phase = S_DONE;
		return r;
	endfunction

	function automatic bit parse_byte(logic [7:0] b, logic sof, output entry_report_t r);
		longint cnt, total, dir_end, w, h, off, need;
		int nul;
		status_t st;
		logic [NameW-1:0] nm;
		if (sof) begin
			phase = S_HEADER; pos = 0;
			foreach (hold[k]) hold[k] = 0;
			decl_cnt = 0; decl_total = 0; prev_end = 0; accepted = 0;
			if (file_len < 12 || file_len > FileMax) begin
				r = mk(ST_SIZE, 0, 0, 0, 0, 0, 0, 1);
				return 1;
			end
		end
		if (phase == S_HEADER) begin
			if (pos < 12) hold[pos] = b;
			pos++;
			if (pos == 4 && {hold[0], hold[1], hold[2], hold[3]} != "IMG1") begin
				r = mk(ST_MAGIC, 0, 0, 0, 0, 0, 0, 1);
				return 1;
			end
			if (pos != 12)
				return 0;
			cnt = {hold[7], hold[6], hold[5], hold[4]};
			total = {hold[11], hold[10], hold[9], hold[8]};
			dir_end = 12 + cnt * 24;
			if (total != file_len) begin
				r = mk(ST_MISMATCH, 0, 0, 0, 0, 0, 0, 1);
				return 1;
			end
			if (cnt == 0 || cnt > 4096) begin
				r = mk(ST_COUNT, 0, 0, 0, 0, 0, 0, 1);
				return 1;
			end
			if (dir_end > total) begin
				r = mk(ST_DIR_OVR, 0, 0, 0, 0, 0, cnt, 1);
				return 1;
			end
			decl_cnt = cnt; decl_total = total; prev_end = dir_end;
			phase = S_DIR; pos = 0;
			return 0;
		end
		if (phase != S_DIR)
			return 0;
		hold[pos] = b;
		pos++;
		if (pos < 24)
			return 0;
		pos = 0;
		// name field is bytes 0..15, compare covers the first 15
		st = ST_OK;
		nul = 16;
		for (int k = 15; k >= 0; k--)
			if (hold[k] == 0) nul = k;
		for (int k = 0; k < NameBytes; k++)
			nm[8*k +: 8] = hold[k];
		if (nul == 16)
			st = ST_UNTERM;
		else if (nul == 0)
			st = ST_EMPTY;
		else begin
			for (int k = 0; k < nul; k++)
				if (st == ST_OK && !((hold[k] >= "a" && hold[k] <= "z") ||
						(hold[k] >= "0" && hold[k] <= "9") || hold[k] == "_"))
					st = ST_BAD_CHAR;
			for (int k = nul + 1; k < 16; k++)
				if (st == ST_OK && hold[k] != 0)
					st = ST_PADDING;
			for (int j = 0; j < accepted; j++)
				if (st == ST_OK && seen_names[j] == nm)
					st = ST_DUP;
		end
		w = {hold[17], hold[16]};
		h = {hold[19], hold[18]};
		off = {hold[23], hold[22], hold[21], hold[20]};
		need = w * h * 3;
		dir_end = 12 + decl_cnt * 24;
		if (st == ST_OK) begin
			if (w == 0 || h == 0) st = ST_ZERO;
			else if (off[1:0] != 0) st = ST_ALIGN;
			else if (off < dir_end) st = ST_OVER_DIR;
			else if (off < prev_end) st = ST_OVERLAP;
			else if (off + need > decl_total) st = ST_DATA_OVR;
		end
		if (st != ST_OK) begin
			r = mk(st, accepted, 0, 0, 0, 0, decl_cnt, 1);
			return 1;
		end
		seen_names[accepted] = nm;
		prev_end = off + need;
		accepted++;
		r = mk(ST_OK, accepted - 1, w, h, off, off + w * h * 2, decl_cnt, accepted >= decl_cnt);
		return 1;
	endfunction

	function automatic bit idle_roll();
		// long stretch without idles or output stalls in the middle of the run
		if (cyc >= 3000 && cyc < 7000)
			return 0;
		return $urandom_range(99) < 24;
	endfunction

	// sender
	always @(posedge clk) begin
		entry_report_t r;
		file_byte_t it;
		cyc <= cyc + 1;
		if (arst_n) begin
			if (in_valid && !in_stall)
				if (parse_byte(data_byte, start_of_file, r))
					report_q.push_back(r);
			if (!in_valid || !in_stall) begin
				if (byte_q.size() > 0 && !idle_roll()) begin
					it = byte_q.pop_front();
					in_valid <= 1;
					data_byte <= it.b;
					start_of_file <= it.sof;
				end else
					in_valid <= 0;
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		entry_report_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (report_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: status %0d entry %0d", status, entry_index);
				end else begin
					e = report_q.pop_front();
					if (status !== e.st || entry_index !== e.idx || width !== e.w ||
							height !== e.h || color_offset !== e.co || alpha_offset !== e.ao ||
							image_count !== e.cnt || last !== e.lst) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp st %0d idx %0d w %0d h %0d co %0d ao %0d cnt %0d last %0d, got st %0d idx %0d w %0d h %0d co %0d ao %0d cnt %0d last %0d",
								e.st, e.idx, e.w, e.h, e.co, e.ao, e.cnt, e.lst, status,
								entry_index, width, height, color_offset, alpha_offset,
								image_count, last);
					end
				end
			end
			out_stall <= idle_roll();
		end
	end

	task automatic drain();
		while (in_valid || byte_q.size() > 0 || report_q.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic set_length(longint v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= v[26:0];
		@(posedge clk);
		file_len = v[26:0];
		cfg_we <= 0;
	endtask

	task automatic push(logic [7:0] b, logic sof);
		byte_q.push_back('{b, sof});
		bytes_queued++;
	endtask

	task automatic push_header(logic [31:0] magic, logic [31:0] cnt, logic [31:0] total);
		for (int k = 3; k >= 0; k--) push(magic[8*k +: 8], k == 3);
		for (int k = 0; k < 4; k++) push(cnt[8*k +: 8], 0);
		for (int k = 0; k < 4; k++) push(total[8*k +: 8], 0);
	endtask

	task automatic push_entry(string nm, logic [15:0] w, logic [15:0] h, logic [31:0] off);
		for (int k = 0; k < 16; k++) push(k < nm.len() ? nm[k] : 8'h00, 0);
		push(w[7:0], 0); push(w[15:8], 0); push(h[7:0], 0); push(h[15:8], 0);
		for (int k = 0; k < 4; k++) push(off[8*k +: 8], 0);
	endtask

	function automatic logic [7:0] name_char(int unsigned n);
		string cs = "abcdefghijklmnopqrstuvwxyz0123456789_";
		return cs[n % 37];
	endfunction

	// builds one file of k entries, fault 0 gives a clean file
	task automatic random_file(int k, int fault);
		logic [7:0] d[];
		longint ew[], eh[], eo[];
		longint pe, total, dir_end, cnt;
		int len, e, keep;
		d = new[24 * k];
		ew = new[k]; eh = new[k]; eo = new[k];
		dir_end = 12 + 24 * k;
		pe = dir_end;
		cnt = k;
		for (int i = 0; i < k; i++) begin
			len = $urandom_range(15, 1);
			for (int j = 0; j < 16; j++)
				d[24*i + j] = j < len ? name_char($urandom) : 8'h00;
			d[24*i] = 8'("a" + i % 26);
			if (len > 1) d[24*i + 1] = 8'("0" + (i / 26) % 10);
			ew[i] = $urandom_range(9) == 0 ? $urandom_range(65535, 1) : $urandom_range(16, 1);
			eh[i] = $urandom_range(9) == 0 ? $urandom_range(65535, 1) : $urandom_range(16, 1);
			if (ew[i] * eh[i] * 3 > 1000000) eh[i] = 1;
			eo[i] = ((pe + 3) & ~64'd3) + 4 * $urandom_range(3);
			pe = eo[i] + ew[i] * eh[i] * 3;
		end
		total = pe + $urandom_range(7);
		e = $urandom_range(k - 1);
		case (fault)
			2: if (e > 0) for (int j = 0; j < 16; j++) d[24*e + j] = d[24*(e-1) + j];
			3: ew[e] = 0;
			4: eo[e] = eo[e] + $urandom_range(3, 1);
			5: eo[e] = (dir_end - 4) & ~64'd3;
			6: if (e > 0) eo[e] = eo[e - 1];
			7: total = pe - 1;
			8: for (int j = 0; j < 16; j++) d[24*e + j] = "q";
			9: d[24*e] = 8'h00;
			10: d[24*e] = $urandom_range(1) ? "A" : 8'hff;
			11: d[24*e + 15] = 8'($urandom_range(255, 1));
			12: cnt = $urandom;
			default: ;
		endcase
		for (int i = 0; i < k; i++) begin
			d[24*i + 16] = ew[i][7:0]; d[24*i + 17] = ew[i][15:8];
			d[24*i + 18] = eh[i][7:0]; d[24*i + 19] = eh[i][15:8];
			for (int j = 0; j < 4; j++) d[24*i + 20 + j] = eo[i][8*j +: 8];
		end
		if (fault == 1) d[$urandom_range(24 * k - 1)] = 8'($urandom);
		set_length(fault == 14 ? total + 1 : total);
		push_header(fault == 13 ? {8'h49, 8'h4d, 8'h47, 8'($urandom)} : "IMG1",
			cnt, total);
		keep = fault == 15 ? $urandom_range(24 * k - 1) : 24 * k;
		for (int i = 0; i < keep; i++) push(d[i], 0);
		// trailing bytes after the file is over are dropped
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(5, 1)) push(8'($urandom), 0);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		// bytes while idle, then a start with the reset length of zero
		push(8'h49, 0); push(8'hff, 0); push(8'h00, 0);
		push(8'h49, 1);
		set_length(11); push(8'h00, 1);
		set_length(27'h7ffffff); push(8'hff, 1);
		set_length(FileMax + 1); push(8'h49, 1);
		set_length(12);
		push_header("IMG1", 1, 12);
		push_header("IMG2", 1, 12);
		push_header("IMG1", 1, 13);
		push_header("IMG1", 0, 12);
		push_header("IMG1", 4097, 12);
		set_length(12 + 24 * 4096);
		push_header("IMG1", 4096, 12 + 24 * 4096);
		push_entry("zero_w", 0, 1, 200000);
		set_length(FileMax);
		push_header("IMG1", 1, FileMax);
		push_entry("z_9", 16'hffff, 1, 66912256);
		set_length(12 + 24 * 2 + 6);
		push_header("IMG1", 2, 12 + 24 * 2 + 6);
		push_entry("ab", 1, 1, 60);
		push_entry("abcdefghijklmno", 1, 1, 64);
		while (bytes_queued < 1700)
			random_file($urandom_range(4) == 0 ? $urandom_range(30, 1) : $urandom_range(5, 1),
				$urandom_range(2) == 0 ? $urandom_range(15, 1) : 0);
		drain();
		errors += report_q.size();
		if (errors == 0)
			$display("** image_pack_directory_validator: PASSED **");
		else
			$display("** image_pack_directory_validator: FAILED **");
		$finish;
	end

	initial begin
		#12000000;
		$display("** image_pack_directory_validator: FAILED **");
		$finish;
	end

endmodule
